// ===== rtl/core/hlr_pkg.sv =====
// Shared types, constants and state codes for the histogram largest-rectangle unit.
`timescale 1ns / 1ps

package hlr_pkg;

  localparam int MAX_BARS_DEF    = 1024;
  localparam int HEIGHT_BITS_DEF = 16;
  localparam int BAR_W           = 16;
  localparam int AREA_BITS       = 26;

  localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic [BAR_W-1:0] bar_height;
    logic             last_bar;
  } bar_beat_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] max_area;
    logic                 overflow;
  } result_beat_t;

  typedef struct packed {
    logic go;
    logic clr;
  } area_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_POP,
    ST_FLUSH,
    ST_DRAIN,
    ST_OUT
  } hlr_state_t;

endpackage

// ===== rtl/core/histogram_largest_rectangle_unit.sv =====
// Top level: largest rectangle in a histogram, stack kept in a synchronous memory.
//
// Bars arrive on the bar channel (bar_valid / bar_stall / bar), one height per
// beat; last_bar closes the histogram. One result beat (max_area, overflow)
// leaves on the result channel after each closing bar, none otherwise.
// Bars past MAX_BARS are dropped and set overflow.
// An item is compared with the top of the stack; each entry it pops adds a read
// of the entry below the top from the registered stack memory, then a compare.
// Each bar is pushed and popped once. The closing bar also pops every entry
// left on the stack and then drains the area multiplier pipeline.
// The block works on one bar at a time; bar_stall is high while it is busy.
// The result is held on the result channel until taken; while result_stall
// is high no bar is taken. Taking the result clears the block for the next
// histogram. Synchronous reset clears control state only; the stack memory
// needs no clearing since only entries pushed in the current histogram are read.
`timescale 1ns / 1ps

module histogram_largest_rectangle_unit
  import hlr_pkg::*;
#(
  parameter int MAX_BARS    = MAX_BARS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         bar_valid,
  output logic         bar_stall,
  input  bar_beat_t    bar,
  output logic         result_valid,
  input  logic         result_stall,
  output result_beat_t result
);

  localparam int CNT_W = $clog2(MAX_BARS + 1);
  localparam int IDX_W = $clog2(MAX_BARS);
  localparam int ENT_W = IDX_W + HEIGHT_BITS;

  hlr_state_t state, state_next;

  logic [CNT_W-1:0]       depth;
  logic [CNT_W-1:0]       bar_count;
  logic                   overflow_seen;
  logic [HEIGHT_BITS-1:0] h_q;
  logic                   last_q;
  logic                   flushing;
  logic [HEIGHT_BITS-1:0] top_h;
  logic [HEIGHT_BITS-1:0] mul_h;
  logic [CNT_W-1:0]       mul_w;
  logic                   mul_go;

  logic                   bar_acc;
  logic                   result_acc;
  logic                   do_pop;
  logic                   do_push;
  logic                   room;

  logic                   wr_en;
  logic [ENT_W-1:0]       wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENT_W-1:0]       rd_data;
  logic [CNT_W-1:0]       below_sel;
  logic [CNT_W-1:0]       left;

  area_cmd_t              area_cmd;
  logic                   area_busy;
  logic [AREA_BITS-1:0]   best;

  assign bar_stall    = (state != ST_IDLE);
  assign bar_acc      = bar_valid && !bar_stall;
  assign result_valid = (state == ST_OUT);
  assign result_acc   = result_valid && !result_stall;
  assign room         = (bar_count < CNT_W'(MAX_BARS));

  // Pop while the top is not strictly lower than the incoming bar, or on flush.
  assign do_pop  = (depth != '0) &&
                   (((state == ST_CMP) && (top_h >= h_q)) || (state == ST_FLUSH));
  assign do_push = (state == ST_CMP) && !do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (bar_acc) begin
          if (bar_count < CNT_W'(MAX_BARS)) begin
            state_next = ST_CMP;
          end else if (bar.last_bar) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_CMP: begin
        if (do_pop) begin
          state_next = ST_POP;
        end else if (last_q) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        state_next = flushing ? ST_FLUSH : ST_CMP;
      end
      ST_FLUSH: begin
        state_next = do_pop ? ST_POP : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mul_go && !area_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stack memory ports: push at depth, read the entry below the top on pop.
  assign below_sel = depth - CNT_W'(2);
  assign wr_en     = do_push;
  assign wr_data   = {bar_count[IDX_W-1:0], h_q};
  assign rd_en     = do_pop && (depth > CNT_W'(1));
  assign rd_addr   = below_sel[IDX_W-1:0];

  hlr_stack_mem #(
    .DEPTH (MAX_BARS),
    .AW    (IDX_W),
    .DW    (ENT_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (depth[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Left bound of the popped bar: one past the new top, or zero on empty.
  assign left = (depth != '0) ? (CNT_W'(rd_data[ENT_W-1:HEIGHT_BITS]) + CNT_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth         <= '0;
      bar_count     <= '0;
      overflow_seen <= 1'b0;
      flushing      <= 1'b0;
      mul_go        <= 1'b0;
    end else begin
      mul_go <= (state == ST_POP);
      if (bar_acc && !room) begin
        overflow_seen <= 1'b1;
      end
      if (state_next == ST_FLUSH) begin
        flushing <= 1'b1;
      end
      if (do_pop) begin
        depth <= depth - CNT_W'(1);
      end else if (do_push) begin
        depth     <= depth + CNT_W'(1);
        bar_count <= bar_count + CNT_W'(1);
      end
      if (result_acc) begin
        depth         <= '0;
        bar_count     <= '0;
        overflow_seen <= 1'b0;
        flushing      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bar_acc) begin
      h_q    <= HEIGHT_BITS'(bar.bar_height);
      last_q <= bar.last_bar;
    end
    if (do_pop) begin
      mul_h <= top_h;
    end
    if (do_push) begin
      top_h <= h_q;
    end
    if (state == ST_POP) begin
      mul_w <= bar_count - left;
      if (depth != '0) begin
        top_h <= rd_data[HEIGHT_BITS-1:0];
      end
    end
  end

  assign area_cmd.go  = mul_go;
  assign area_cmd.clr = result_acc;

  hlr_area_unit #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .WIDTH_BITS  (CNT_W)
  ) u_area (
    .clk    (clk),
    .rst    (rst),
    .cmd    (area_cmd),
    .height (mul_h),
    .width  (mul_w),
    .busy   (area_busy),
    .best   (best)
  );

  assign result.max_area = best;
  assign result.overflow = overflow_seen;

  // The stack never holds more entries than bars taken.
  assert property (@(posedge clk) disable iff (rst) depth <= bar_count)
    else $error("stack depth exceeds bar count");

  assert property (@(posedge clk) disable iff (rst) bar_count <= CNT_W'(MAX_BARS))
    else $error("bar count past capacity");

  // A result is shown only after the area pipeline has drained.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> (!mul_go && !area_busy))
    else $error("result shown with area work pending");

  // Taking a result leaves an empty histogram behind.
  assert property (@(posedge clk) disable iff (rst)
    result_acc |=> (depth == '0) && (bar_count == '0) && (best == '0) && !overflow_seen)
    else $error("histogram not cleared after result");

  // A pop on a nonempty stack always leads to the read stage.
  assert property (@(posedge clk) disable iff (rst) do_pop |=> (state == ST_POP))
    else $error("pop did not reach read stage");

endmodule

// ===== rtl/core/hlr_stack_mem.sv =====
// Synchronous stack memory, one write port and one registered read port.
`timescale 1ns / 1ps

module hlr_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/hlr_area_unit.sv =====
// Area multiplier, saturation and running maximum.
`timescale 1ns / 1ps

module hlr_area_unit
  import hlr_pkg::*;
#(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int WIDTH_BITS  = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  area_cmd_t              cmd,
  input  logic [HEIGHT_BITS-1:0] height,
  input  logic [WIDTH_BITS-1:0]  width,
  output logic                   busy,
  output logic [AREA_BITS-1:0]   best
);

  localparam int PW = HEIGHT_BITS + WIDTH_BITS;
  localparam int EW = (PW > AREA_BITS) ? PW : AREA_BITS + 1;

  logic [PW-1:0]        prod;
  logic                 prod_v;
  logic [EW-1:0]        prod_e;
  logic [AREA_BITS-1:0] sat;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= cmd.go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      prod <= PW'(height) * PW'(width);
    end
  end

  assign prod_e = EW'(prod);
  assign sat    = (prod_e > EW'(AREA_MAX)) ? AREA_MAX : prod_e[AREA_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      best <= '0;
    end else if (prod_v && (sat > best)) begin
      best <= sat;
    end
  end

  assign busy = prod_v;

endmodule
